### hdl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and types for the sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Default datapath width for base, exponent and modulus.
    localparam int WORD_BITS_DEFAULT = 32;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQR,
        ST_MUL,
        ST_FINISH
    } seq_state_t;

    // Status reported by the modular multiplier to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage
// ----------------------------------------------------------------------------

### hdl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Bit-serial shift-and-add product reduced modulo m, one multiplier bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] op_a,
    input  logic [WORD_BITS-1:0] op_b,
    input  logic [WORD_BITS-1:0] op_m,
    output logic [WORD_BITS-1:0] product,
    output modexp_pkg::mm_stat_t stat
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [WORD_BITS-1:0] dbl;

    // Sum of two residues below m, folded back below m.
    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y,
        input logic [WORD_BITS-1:0] m
    );
        logic [WORD_BITS:0] s;
        logic [WORD_BITS:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        if (s >= {1'b0, m}) begin
            return d[WORD_BITS-1:0];
        end
        return s[WORD_BITS-1:0];
    endfunction

    always_comb begin
        dbl      = add_mod(acc_reg, acc_reg, m_reg);
        acc_next = b_reg[WORD_BITS-1] ? add_mod(dbl, a_reg, m_reg) : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
            m_reg   <= op_m;
            cnt_reg <= CNT_BITS'(WORD_BITS - 1);
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
// ----------------------------------------------------------------------------

### hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Left-to-right square and multiply of base^exponent mod modulus over a
// shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One word is taken at a time: the modular multiplier, one bit per cycle,
// sets the pace, and the next word is taken once the previous one is done.
// Reset: aresetn, synchronous and active low, empties the block and clears
// the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input word
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_base,
    input  logic [WORD_BITS-1:0] s_exponent,
    input  logic [WORD_BITS-1:0] s_modulus,
    // Result word
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_power_residue,
    output logic                 m_zero_modulus_error
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    // The sequencer drives the shared multiplier through five states. On
    // acceptance the base is reduced by multiplying (1 mod m) by the raw
    // base, which the multiplier scans bit by bit; this gives base mod m
    // without a separate divider. Then each exponent bit, from the top,
    // costs one squaring and, if the bit is set, one multiplication by the
    // reduced base.
    modexp_pkg::seq_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] mod_reg, mod_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic                 err_reg, err_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;

    // Output register, so that a finished result can wait for the sink.
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic                 res_err_reg, res_err_next;

    // Multiplier hand-off.
    logic                 mm_start;
    logic [WORD_BITS-1:0] mm_a;
    logic [WORD_BITS-1:0] mm_b;
    logic [WORD_BITS-1:0] mm_m;
    logic [WORD_BITS-1:0] mm_product;
    modexp_pkg::mm_stat_t mm_stat;

    logic [WORD_BITS-1:0] one_mod;

    modexp_mulmod #(
        .WORD_BITS(WORD_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .op_m    (mm_m),
        .product (mm_product),
        .stat    (mm_stat)
    );

    // One reduced modulo the incoming modulus: zero only for a modulus of one.
    assign one_mod = (s_modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= modexp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        mod_reg     <= mod_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        idx_reg     <= idx_next;
        res_reg     <= res_next;
        res_err_reg <= res_err_next;
    end

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        mod_next     = mod_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        res_err_next = res_err_reg;
        m_valid_next = m_valid_reg;
        mm_start     = 1'b0;
        mm_a         = mm_product;
        mm_b         = mm_product;
        mm_m         = mod_reg;

        // The sink takes the waiting result.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    base_next = s_base;
                    exp_next  = s_exponent;
                    mod_next  = s_modulus;
                    acc_next  = one_mod;
                    idx_next  = CNT_BITS'(WORD_BITS - 1);
                    if (s_modulus == '0) begin
                        // No arithmetic at all: report the error at once.
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = modexp_pkg::ST_FINISH;
                    end else begin
                        err_next   = 1'b0;
                        mm_start   = 1'b1;
                        mm_a       = one_mod;
                        mm_b       = s_base;
                        mm_m       = s_modulus;
                        state_next = modexp_pkg::ST_BASE;
                    end
                end
            end
            modexp_pkg::ST_BASE: begin
                if (mm_stat.done) begin
                    base_next  = mm_product;
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    mm_b       = acc_reg;
                    state_next = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_SQR: begin
                if (mm_stat.done) begin
                    acc_next = mm_product;
                    if (exp_reg[idx_reg]) begin
                        mm_start   = 1'b1;
                        mm_b       = base_reg;
                        state_next = modexp_pkg::ST_MUL;
                    end else if (idx_reg == '0) begin
                        state_next = modexp_pkg::ST_FINISH;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                        mm_start = 1'b1;
                    end
                end
            end
            modexp_pkg::ST_MUL: begin
                if (mm_stat.done) begin
                    acc_next = mm_product;
                    if (idx_reg == '0) begin
                        state_next = modexp_pkg::ST_FINISH;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        mm_start   = 1'b1;
                        state_next = modexp_pkg::ST_SQR;
                    end
                end
            end
            modexp_pkg::ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    res_next     = acc_reg;
                    res_err_next = err_reg;
                    m_valid_next = 1'b1;
                    state_next   = modexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready              = (state_reg == modexp_pkg::ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_power_residue      = res_reg;
    assign m_zero_modulus_error = res_err_reg;

    // The multiplier is never restarted while it is still working.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

    // Every product that the multiplier returns is a proper residue.
    a_product_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (mm_product < mod_reg))
        else $error("multiplier product not reduced");

    // The multiplier only finishes while the sequencer is waiting for it.
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (state_reg == modexp_pkg::ST_BASE ||
                          state_reg == modexp_pkg::ST_SQR ||
                          state_reg == modexp_pkg::ST_MUL))
        else $error("multiplier finished outside a multiply state");

    // An error word always carries a zero residue.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_modulus_error) |-> (m_power_residue == '0))
        else $error("error word with non-zero residue");

endmodule
// ----------------------------------------------------------------------------
